/* rtl/core/aat_pkg.sv */
// ----------------------------------------------------------------------------
// aat_pkg
// Shared constants, register indexes and types of the averaged ADC thermostat.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int SAMPLES_PER_AVERAGE = 10;
  localparam int NUM_CHANNELS        = 2;

  localparam int SAMPLE_W   = 8;
  localparam int SUM_W      = 12;
  localparam int MV_W       = 13;
  localparam int CH_W       = 1;
  localparam int CNT_W      = $clog2(SAMPLES_PER_AVERAGE + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int MV_SCALE        = 196;
  localparam int MV_DIVISOR      = 10;
  localparam int MV_OFFSET       = 25;
  localparam int SHORT_LIMIT_MV  = 100;
  localparam int OPEN_LIMIT_MV   = 4900;
  localparam int FIRST_MARGIN_MV = 20;

  // sum*scale/div done as sum*recip >> shift; exact while max_sum*div < 2**shift
  localparam int MV_DIV   = SAMPLES_PER_AVERAGE * MV_DIVISOR;
  localparam int MV_SHIFT = 24;
  localparam longint unsigned MV_RECIP =
      ((64'd1 << MV_SHIFT) * MV_SCALE + MV_DIV - 1) / MV_DIV;
  localparam int RECIP_W = $clog2(MV_RECIP + 1);
  localparam int PROD_W  = SUM_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] REG_HEAT_ON_BELOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_OFF_ABOVE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SET_LED_THRESH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_CHAN   = 2'd3;

  typedef struct packed {
    logic [MV_W-1:0] heat_on_below_mv;
    logic [MV_W-1:0] heat_off_above_mv;
    logic [MV_W-1:0] set_led_threshold_mv;
    logic [CH_W-1:0] control_channel;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
    logic [CH_W-1:0]  channel;
  } avg_beat_t;

endpackage

/* rtl/core/aat_avg.sv */
// ----------------------------------------------------------------------------
// aat_avg
// Input register and one round-robin sample accumulator; hands out a completed
// sum with its channel once every SAMPLES_PER_AVERAGE samples.
// ----------------------------------------------------------------------------
module aat_avg
  import aat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  logic [SAMPLE_W-1:0] adc_sample,
  output avg_beat_t           avg,
  input  logic                avg_ready
);

  logic                s_valid;
  logic [SAMPLE_W-1:0] s_sample;
  logic [SUM_W-1:0]    sum;
  logic [CNT_W-1:0]    count;
  logic [CH_W-1:0]     channel;

  logic [SUM_W-1:0]    sum_next;
  logic                done;
  logic                advance;
  logic [CH_W:0]       ch_inc;
  logic [CH_W-1:0]     channel_next;

  always_comb begin
    sum_next     = sum + SUM_W'(s_sample);
    done         = (count == CNT_W'(SAMPLES_PER_AVERAGE - 1));
    advance      = s_valid && (!done || avg_ready);
    sample_ready = !s_valid || advance;
    ch_inc       = {1'b0, channel} + (CH_W + 1)'(1);
    if (ch_inc >= (CH_W + 1)'(NUM_CHANNELS)) begin
      channel_next = '0;
    end else begin
      channel_next = ch_inc[CH_W-1:0];
    end
    avg.valid   = s_valid && done;
    avg.sum     = sum_next;
    avg.channel = channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      sum     <= '0;
      count   <= '0;
      channel <= '0;
    end else begin
      if (sample_ready) begin
        s_valid <= sample_valid;
      end
      if (advance) begin
        if (done) begin
          sum     <= '0;
          count   <= '0;
          channel <= channel_next;
        end else begin
          sum   <= sum_next;
          count <= count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      s_sample <= adc_sample;
    end
  end

endmodule

/* rtl/core/aat_ctrl.sv */
// ----------------------------------------------------------------------------
// aat_ctrl
// Millivolt conversion, fault and indicator flags, heater hysteresis and the
// result register.
// ----------------------------------------------------------------------------
module aat_ctrl
  import aat_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  avg_beat_t       avg,
  output logic            avg_ready,
  output logic            result_valid,
  input  logic            result_ready,
  output logic [CH_W-1:0] avg_channel,
  output logic [MV_W-1:0] avg_millivolts,
  output logic            control_valid,
  output logic            heater_on,
  output logic            set_led_on,
  output logic            short_fault,
  output logic            open_fault
);

  logic heater_state;
  logic first_pending;

  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]   mv;
  logic [MV_W-1:0]   first_limit;
  logic              ctl;
  logic              shrt;
  logic              opn;
  logic              led;
  logic              heater_next;
  logic              pending_next;
  logic              take;

  always_comb begin
    prod = PROD_W'(avg.sum) * PROD_W'(MV_RECIP);
    mv   = MV_W'(prod >> MV_SHIFT) + MV_W'(MV_OFFSET);
    ctl  = (avg.channel == cfg.control_channel);
    led  = ctl && (mv >= MV_W'(cfg.set_led_threshold_mv));
    shrt = ctl && (mv <= MV_W'(SHORT_LIMIT_MV));
    opn  = ctl && !shrt && (mv >= MV_W'(OPEN_LIMIT_MV));
    if (cfg.heat_off_above_mv >= MV_W'(FIRST_MARGIN_MV)) begin
      first_limit = cfg.heat_off_above_mv - MV_W'(FIRST_MARGIN_MV);
    end else begin
      first_limit = '0;
    end
    heater_next  = heater_state;
    pending_next = first_pending;
    if (ctl) begin
      if (shrt || opn) begin
        heater_next = 1'b0;
      end else if (first_pending) begin
        pending_next = 1'b0;
        heater_next  = (mv < first_limit);
      end else if (mv < cfg.heat_on_below_mv) begin
        heater_next = 1'b1;
      end else if (mv > cfg.heat_off_above_mv) begin
        heater_next = 1'b0;
      end
    end
    avg_ready = !result_valid || result_ready;
    take      = avg.valid && avg_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      heater_state  <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      if (avg_ready) begin
        result_valid <= avg.valid;
      end
      if (take) begin
        heater_state  <= heater_next;
        first_pending <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      avg_channel    <= avg.channel;
      avg_millivolts <= mv;
      control_valid  <= ctl;
      heater_on      <= heater_next;
      set_led_on     <= led;
      short_fault    <= shrt;
      open_fault     <= opn;
    end
  end

endmodule

/* rtl/core/averaged_adc_thermostat.sv */
// ----------------------------------------------------------------------------
// averaged_adc_thermostat
// On/off thermostat with hysteresis fed by averaged round-robin ADC samples.
// The last sample of an average passes the input register, then the result
// register; samples are taken one per cycle unless a closing sample waits.
// Sample beats that do not close an average pass even while a result waits.
// Reset: sync, clears sums, count, channel, heater off, first decision armed,
// threshold registers return to their defaults.
// ----------------------------------------------------------------------------
module averaged_adc_thermostat
  import aat_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  logic [SAMPLE_W-1:0]   adc_sample,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [CH_W-1:0]       avg_channel,
  output logic [MV_W-1:0]       avg_millivolts,
  output logic                  control_valid,
  output logic                  heater_on,
  output logic                  set_led_on,
  output logic                  short_fault,
  output logic                  open_fault,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  avg_beat_t avg;
  logic      avg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_on_below_mv     <= MV_W'(1660);
      cfg.heat_off_above_mv    <= MV_W'(1760);
      cfg.set_led_threshold_mv <= MV_W'(1800);
      cfg.control_channel      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEAT_ON_BELOW:  cfg.heat_on_below_mv     <= cfg_data[MV_W-1:0];
        REG_HEAT_OFF_ABOVE: cfg.heat_off_above_mv    <= cfg_data[MV_W-1:0];
        REG_SET_LED_THRESH: cfg.set_led_threshold_mv <= cfg_data[MV_W-1:0];
        REG_CONTROL_CHAN:   cfg.control_channel      <= cfg_data[CH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aat_avg u_avg (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .adc_sample   (adc_sample),
    .avg          (avg),
    .avg_ready    (avg_ready)
  );

  aat_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .avg            (avg),
    .avg_ready      (avg_ready),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .avg_channel    (avg_channel),
    .avg_millivolts (avg_millivolts),
    .control_valid  (control_valid),
    .heater_on      (heater_on),
    .set_led_on     (set_led_on),
    .short_fault    (short_fault),
    .open_fault     (open_fault)
  );

endmodule
